[src/hpss_pkg.sv]
`timescale 1ns / 1ps
// Package for the heat plate stencil block: item codes, register map,
// field widths and the shared configuration and command types.
// No dependencies; every other file refers to it by scoped names.
package hpss_pkg;

    // Field widths fixed by the item and register formats.
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 6;
    localparam int WORD_W     = 16;
    localparam int RATE_W     = 15;
    localparam int FIRST_W    = 6;
    localparam int END_W      = 7;
    localparam int KEEP_W     = 17;

    // Rate arithmetic in Q0.16.
    localparam int RATE_ONE   = 65536;
    localparam int RATE_MAX   = 16384;
    localparam int ROUND_HALF = 32768;

    // Pipeline stages between the last read issue and the last write.
    localparam int DRAIN_LEN  = 3;

    // Configuration port geometry.
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    // Register reset values.
    localparam logic [RATE_W-1:0]  RST_RATE  = 15'd13107;
    localparam logic [WORD_W-1:0]  RST_COLD  = 16'd5120;
    localparam logic [WORD_W-1:0]  RST_HOT   = 16'd25600;
    localparam logic [FIRST_W-1:0] RST_FIRST = 6'd25;
    localparam logic [END_W-1:0]   RST_END   = 7'd38;

    // Item operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_STEP  = 2'd3
    } t_mode;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_RATE  = 3'd0,
        REG_COLD  = 3'd1,
        REG_HOT   = 3'd2,
        REG_FIRST = 3'd3,
        REG_END   = 3'd4
    } t_reg;

    // Configuration register contents.
    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [WORD_W-1:0]  cold;
        logic [WORD_W-1:0]  hot;
        logic [FIRST_W-1:0] src_first;
        logic [END_W-1:0]   src_end;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic init_wr;
        logic step_issue;
        logic swap;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

[src/hpss_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the heat plate stencil block:
// the command word channel and the result word channel. Uses hpss_pkg.
interface hpss_in_if;
    logic                             valid;
    logic                             ready;
    logic [hpss_pkg::MODE_W-1:0]      mode;
    logic [hpss_pkg::COORD_W-1:0]     row;
    logic [hpss_pkg::COORD_W-1:0]     column;
    logic [hpss_pkg::WORD_W-1:0]      write_temperature;

    modport source (output valid, mode, row, column, write_temperature, input ready);
    modport sink   (input valid, mode, row, column, write_temperature, output ready);
endinterface

interface hpss_out_if;
    logic                         valid;
    logic                         ready;
    logic [hpss_pkg::WORD_W-1:0]  read_temperature;

    modport source (output valid, read_temperature, input ready);
    modport sink   (input valid, read_temperature, output ready);
endinterface

[src/hpss_cfg.sv]
`timescale 1ns / 1ps
// Configuration register bank behind an APB-style port.
// Depends on hpss_pkg for the register map and reset values.
module hpss_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpss_pkg::APB_AW-1:0]   paddr,
    input  logic [hpss_pkg::APB_DW-1:0]   pwdata,
    output logic [hpss_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output hpss_pkg::t_cfg                o_cfg
);
    hpss_pkg::t_cfg r_cfg;
    hpss_pkg::t_reg reg_idx;
    logic           wr_en;

    assign reg_idx = hpss_pkg::t_reg'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate      <= hpss_pkg::RST_RATE;
            r_cfg.cold      <= hpss_pkg::RST_COLD;
            r_cfg.hot       <= hpss_pkg::RST_HOT;
            r_cfg.src_first <= hpss_pkg::RST_FIRST;
            r_cfg.src_end   <= hpss_pkg::RST_END;
        end else if (wr_en) begin
            case (reg_idx)
                hpss_pkg::REG_RATE:  r_cfg.rate      <= pwdata[hpss_pkg::RATE_W-1:0];
                hpss_pkg::REG_COLD:  r_cfg.cold      <= pwdata[hpss_pkg::WORD_W-1:0];
                hpss_pkg::REG_HOT:   r_cfg.hot       <= pwdata[hpss_pkg::WORD_W-1:0];
                hpss_pkg::REG_FIRST: r_cfg.src_first <= pwdata[hpss_pkg::FIRST_W-1:0];
                hpss_pkg::REG_END:   r_cfg.src_end   <= pwdata[hpss_pkg::END_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (reg_idx)
            hpss_pkg::REG_RATE:  prdata = hpss_pkg::APB_DW'(r_cfg.rate);
            hpss_pkg::REG_COLD:  prdata = hpss_pkg::APB_DW'(r_cfg.cold);
            hpss_pkg::REG_HOT:   prdata = hpss_pkg::APB_DW'(r_cfg.hot);
            hpss_pkg::REG_FIRST: prdata = hpss_pkg::APB_DW'(r_cfg.src_first);
            hpss_pkg::REG_END:   prdata = hpss_pkg::APB_DW'(r_cfg.src_end);
            default:             prdata = '0;
        endcase
    end
endmodule

[src/hpss_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences item acceptance, the plate sweeps,
// the pipeline drain and the hand-over of the result. Uses hpss_pkg.
module hpss_ctrl #(
    parameter int GRID_SIDE = 64,
    parameter int A_W       = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [hpss_pkg::MODE_W-1:0]  i_mode,
    input  hpss_pkg::t_stat              i_stat,
    output logic                         o_ready,
    output hpss_pkg::t_cmd               o_cmd,
    output logic [A_W:0]                 o_q
);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_STEP  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [A_W:0]  r_q, n_q;
    hpss_pkg::t_mode mode;

    assign mode    = hpss_pkg::t_mode'(i_mode);
    assign o_ready = (r_state == S_IDLE);
    assign o_q     = r_q;

    // Next state, sweep counter and commands.
    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_q          = '0;
                    case (mode)
                        hpss_pkg::MODE_INIT: n_state = S_INIT;
                        hpss_pkg::MODE_STEP: n_state = S_STEP;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_q           = r_q + 1'b1;
                if (r_q == (A_W+1)'(CELLS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_STEP: begin
                o_cmd.step_issue = 1'b1;
                n_q              = r_q + 1'b1;
                if (r_q == (A_W+1)'(CELLS)) begin
                    n_q     = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_q = r_q + 1'b1;
                if (r_q == (A_W+1)'(hpss_pkg::DRAIN_LEN - 1)) begin
                    o_cmd.swap = 1'b1;
                    n_state    = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
        end
    end
endmodule

[src/hpss_dp.sv]
`timescale 1ns / 1ps
// Datapath: the two plate memories, the line buffer, the stencil pipeline
// and the result register. Driven by hpss_ctrl commands; uses hpss_pkg.
module hpss_dp #(
    parameter int GRID_SIDE = 64,
    parameter int TEMP_BITS = 16,
    parameter int IDX_W     = 6,
    parameter int A_W       = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpss_pkg::t_cmd                i_cmd,
    input  logic [A_W:0]                  i_q,
    input  hpss_pkg::t_cfg                i_cfg,
    input  logic [hpss_pkg::MODE_W-1:0]   i_mode,
    input  logic [hpss_pkg::COORD_W-1:0]  i_row,
    input  logic [hpss_pkg::COORD_W-1:0]  i_column,
    input  logic [hpss_pkg::WORD_W-1:0]   i_wtemp,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [hpss_pkg::WORD_W-1:0]   o_res_data,
    output hpss_pkg::t_stat               o_stat
);
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int SUM_W  = TEMP_BITS + 2;
    localparam int PC_W   = TEMP_BITS + hpss_pkg::KEEP_W;
    localparam int PS_W   = SUM_W + hpss_pkg::RATE_W;
    localparam int ACC_W  = TEMP_BITS + 18;

    // Plate memories and the one-row line buffer.
    logic [TEMP_BITS-1:0] grid_a [CELLS];
    logic [TEMP_BITS-1:0] grid_b [CELLS];
    logic [TEMP_BITS-1:0] lbuf   [GRID_SIDE];

    logic                 r_front;
    logic [TEMP_BITS-1:0] r_a_rda, r_a_rdb, r_b_rda, r_b_rdb;
    logic                 r_is_read, r_inside;
    logic                 r_out_valid;
    logic [hpss_pkg::WORD_W-1:0] r_out_data;

    hpss_pkg::t_mode      mode;
    logic                 in_inside;
    logic [A_W-1:0]       in_addr;
    logic                 wr_item, rd_item, rd_en;
    logic [A_W-1:0]       rd_addr_a, rd_addr_b;
    logic [A_W-1:0]       wr_addr;
    logic [TEMP_BITS-1:0] wr_data;
    logic                 we_a, we_b;
    logic [TEMP_BITS-1:0] hot_t, cold_t;

    // Cell position counters shared by the initialise and step sweeps.
    logic [IDX_W-1:0]     r_krow, r_kcol;
    logic                 adv;
    logic                 pos_src, pos_bnd;

    // Stage 1: window assembly.
    logic                 r_v1, r_first1;
    logic [A_W:0]         r_q1;
    logic [TEMP_BITS-1:0] r_e1, r_e2, r_lbq;
    logic [IDX_W-1:0]     r_lbp;
    logic [TEMP_BITS-1:0] nb_s, nb_e;
    logic [SUM_W-1:0]     sum1;

    // Stage 2 and 3 registers.
    logic                 r2_v, r2_bnd, r2_src;
    logic [TEMP_BITS-1:0] r2_c;
    logic [SUM_W-1:0]     r2_sum;
    logic [A_W-1:0]       r2_addr;
    logic                 r3_v, r3_bnd, r3_src;
    logic [TEMP_BITS-1:0] r3_c;
    logic [PC_W-1:0]      r3_pc;
    logic [PS_W-1:0]      r3_ps;
    logic [A_W-1:0]       r3_addr;

    logic [hpss_pkg::RATE_W-1:0] rate_sat;
    logic [hpss_pkg::KEEP_W-1:0] keep;
    logic [ACC_W-1:0]     acc;
    logic [TEMP_BITS-1:0] step_val;

    // Decode of the incoming word.
    assign mode      = hpss_pkg::t_mode'(i_mode);
    assign in_inside = (int'(i_row) < GRID_SIDE) && (int'(i_column) < GRID_SIDE);
    assign in_addr   = A_W'(int'(i_row) * GRID_SIDE + int'(i_column));
    assign wr_item   = i_cmd.accept && (mode == hpss_pkg::MODE_WRITE) && in_inside;
    assign rd_item   = i_cmd.accept && (mode == hpss_pkg::MODE_READ);
    assign hot_t     = TEMP_BITS'(i_cfg.hot);
    assign cold_t    = TEMP_BITS'(i_cfg.cold);

    // Read ports: port A runs one row ahead (south), port B one cell ahead (east).
    assign rd_en     = i_cmd.step_issue || rd_item;
    assign rd_addr_a = A_W'(i_q + (A_W+1)'(GRID_SIDE - 1));
    assign rd_addr_b = i_cmd.step_issue ? A_W'(i_q) : in_addr;

    // Source square and plate edge tests for the current position.
    assign pos_src = (int'(r_krow) >= int'(i_cfg.src_first)) &&
                     (int'(r_krow) <  int'(i_cfg.src_end)) &&
                     (int'(r_kcol) >= int'(i_cfg.src_first)) &&
                     (int'(r_kcol) <  int'(i_cfg.src_end));
    assign pos_bnd = (r_krow == '0) || (r_kcol == '0) ||
                     (r_krow == IDX_W'(GRID_SIDE - 1)) ||
                     (r_kcol == IDX_W'(GRID_SIDE - 1));

    // Write port selection: initialise writes both grids, a write word the
    // front grid, the stencil pipeline the back grid.
    always_comb begin
        if (i_cmd.init_wr) begin
            wr_addr = A_W'(i_q);
            wr_data = pos_src ? hot_t : cold_t;
        end else if (r3_v) begin
            wr_addr = r3_addr;
            wr_data = step_val;
        end else begin
            wr_addr = in_addr;
            wr_data = TEMP_BITS'(i_wtemp);
        end
    end
    assign we_a = i_cmd.init_wr || (wr_item && !r_front) || (r3_v && r_front);
    assign we_b = i_cmd.init_wr || (wr_item && r_front)  || (r3_v && !r_front);

    // Grid A memory.
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            grid_a[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_a_rda <= grid_a[rd_addr_a];
            r_a_rdb <= grid_a[rd_addr_b];
        end
    end

    // Grid B memory.
    always_ff @(posedge i_clk) begin
        if (we_b) begin
            grid_b[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_b_rda <= grid_b[rd_addr_a];
            r_b_rdb <= grid_b[rd_addr_b];
        end
    end

    // Front grid selection of the read words.
    assign nb_s = r_front ? r_b_rda : r_a_rda;
    assign nb_e = r_front ? r_b_rdb : r_a_rdb;

    // Line buffer delays the centre stream by one row to give the north cell.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_lbq        <= lbuf[r_lbp];
            lbuf[r_lbp]  <= nb_e;
        end
    end

    // Stage 1 control and window shift.
    assign adv  = i_cmd.init_wr || (r_v1 && !r_first1);
    assign sum1 = SUM_W'(nb_s) + SUM_W'(nb_e) + SUM_W'(r_e2) + SUM_W'(r_lbq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_lbp    <= '0;
            r_krow   <= '0;
            r_kcol   <= '0;
        end else begin
            r_v1     <= i_cmd.step_issue;
            r_first1 <= (i_q == '0);
            if (i_cmd.accept) begin
                r_lbp <= '0;
            end else if (r_v1) begin
                r_lbp <= (r_lbp == IDX_W'(GRID_SIDE - 1)) ? '0 : r_lbp + 1'b1;
            end
            if (i_cmd.accept) begin
                r_krow <= '0;
                r_kcol <= '0;
            end else if (adv) begin
                if (r_kcol == IDX_W'(GRID_SIDE - 1)) begin
                    r_kcol <= '0;
                    r_krow <= r_krow + 1'b1;
                end else begin
                    r_kcol <= r_kcol + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1 <= i_q;
        if (r_v1) begin
            r_e1 <= nb_e;
            r_e2 <= r_e1;
        end
    end

    // Stage 2: centre, neighbour sum and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r_v1 && !r_first1;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_c    <= r_e1;
        r2_sum  <= sum1;
        r2_bnd  <= pos_bnd;
        r2_src  <= pos_src;
        r2_addr <= A_W'(r_q1 - 1'b1);
    end

    // Rate clamp and the weight kept by the centre cell.
    assign rate_sat = (int'(i_cfg.rate) > hpss_pkg::RATE_MAX) ?
                      hpss_pkg::RATE_W'(hpss_pkg::RATE_MAX) : i_cfg.rate;
    assign keep     = hpss_pkg::KEEP_W'(hpss_pkg::RATE_ONE) -
                      {rate_sat, 2'b00};

    // Stage 3: the two products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pc   <= PC_W'(keep) * PC_W'(r2_c);
        r3_ps   <= PS_W'(rate_sat) * PS_W'(r2_sum);
        r3_c    <= r2_c;
        r3_bnd  <= r2_bnd;
        r3_src  <= r2_src;
        r3_addr <= r2_addr;
    end

    // Round to nearest and pick the value written to the back grid.
    assign acc      = ACC_W'(r3_pc) + ACC_W'(r3_ps) + ACC_W'(hpss_pkg::ROUND_HALF);
    assign step_val = r3_src ? hot_t : (r3_bnd ? r3_c : acc[TEMP_BITS+15:16]);

    // Front grid selection flips at the end of a step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= 1'b0;
        end else if (i_cmd.swap) begin
            r_front <= !r_front;
        end
    end

    // Word kind held for the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_read <= rd_item;
            r_inside  <= in_inside;
        end
    end

    // Result register; it lets the next word in while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= (r_is_read && r_inside) ? hpss_pkg::WORD_W'(nb_e) : '0;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_res_data      = r_out_data;
    assign o_stat.out_free = !r_out_valid || i_res_ready;
endmodule

[src/heat_plate_stencil_step_core.sv]
`timescale 1ns / 1ps
// Top level of the heat plate stencil block: controller, datapath and
// configuration bank. Depends on hpss_pkg, hpss_if, hpss_cfg, hpss_ctrl, hpss_dp.
//
//  Channel   Dir  Handshake           Word
//  i_item    in   valid/ready         mode, row, column, write_temperature
//  o_result  out  valid/ready         read_temperature
//  APB       in   psel/penable/pready register writes and reads
//
// Read and write words pass from acceptance through the finish state to the result register.
// Initialise writes one cell a cycle into both grids.
// A step streams one cell a cycle through the front
// grid's two read ports, a one-row line buffer and a three-stage stencil pipeline.
// Reset is synchronous, active low; the grids hold no reset value.
// A new word is taken while a result waits; a full result register stalls completion.
module heat_plate_stencil_step_core #(
    parameter int GRID_SIDE = 64,
    parameter int TEMP_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hpss_in_if.sink                       i_item,
    hpss_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpss_pkg::APB_AW-1:0]   paddr,
    input  logic [hpss_pkg::APB_DW-1:0]   pwdata,
    output logic [hpss_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int A_W   = $clog2(GRID_SIDE * GRID_SIDE);

    hpss_pkg::t_cfg  cfg;
    hpss_pkg::t_cmd  cmd;
    hpss_pkg::t_stat stat;
    logic [A_W:0]    q;

    // Register bank.
    hpss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer.
    hpss_ctrl #(
        .GRID_SIDE (GRID_SIDE),
        .A_W       (A_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_ready (i_item.ready),
        .o_cmd   (cmd),
        .o_q     (q)
    );

    // Plate memories and stencil arithmetic.
    hpss_dp #(
        .GRID_SIDE (GRID_SIDE),
        .TEMP_BITS (TEMP_BITS),
        .IDX_W     (IDX_W),
        .A_W       (A_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_q         (q),
        .i_cfg       (cfg),
        .i_mode      (i_item.mode),
        .i_row       (i_item.row),
        .i_column    (i_item.column),
        .i_wtemp     (i_item.write_temperature),
        .i_res_ready (o_result.ready),
        .o_res_valid (o_result.valid),
        .o_res_data  (o_result.read_temperature),
        .o_stat      (stat)
    );
endmodule
